// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the vehicle kinematic step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is active.
`define VKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define VKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/vks_pkg.sv =====
// Package: widths, CORDIC table, controller states and command types.
`timescale 1ns / 1ps
package vks_pkg;

  // Field widths
  localparam int ANGLE_BITS = 24;
  localparam int TRIG_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int VEL_W      = 32;
  localparam int ACC_W      = 24;
  localparam int YAW_W      = 32;
  localparam int DT_W       = 16;

  localparam logic [DT_W-1:0] TICK_PERIOD_RST = 16'd6554;

  // Trig values carry TRIG_FRAC fraction bits
  localparam int TRIG_FRAC  = TRIG_BITS - 2;

  // CORDIC: 30 rotations at scale 2^30
  localparam int CORD_STEPS = 30;
  localparam int CORD_IW    = $clog2(CORD_STEPS);
  localparam int CORD_RSH   = 30 - TRIG_FRAC;
  localparam int CORD_W     = 34;
  localparam int CORD_ZW    = 33;
  localparam logic signed [CORD_W-1:0] CORD_GAIN = 34'sd652032874;

  // Shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = (TRIG_BITS > DT_W + 1) ? TRIG_BITS : DT_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Saturation input width
  localparam int SAT_W = POS_W + 4;

  typedef logic [CORD_IW-1:0] cord_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DV,
    MUL_DH,
    MUL_STEP,
    MUL_DX,
    MUL_DY
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DV,
    ST_DH,
    ST_HEAD,
    ST_CINIT,
    ST_CORD,
    ST_CFIN,
    ST_MX,
    ST_MY,
    ST_PY,
    ST_DONE
  } vks_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic      load_ctrl;
    mul_sel_t  mul_sel;
    logic      upd_vel;
    logic      upd_head;
    logic      load_step;
    logic      cord_init;
    logic      cord_step;
    cord_idx_t cord_idx;
    logic      trig_load;
    logic      upd_px;
    logic      upd_py;
    logic      out_load;
  } vks_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_busy;
  } vks_sts_t;

  // arctan(2^-i) at scale 2^30 per quarter turn
  function automatic logic signed [CORD_ZW-1:0] cord_atan(input cord_idx_t i);
    logic signed [CORD_ZW-1:0] a;
    case (i)
      5'd0:    a = CORD_ZW'(536870912);
      5'd1:    a = CORD_ZW'(316933406);
      5'd2:    a = CORD_ZW'(167458907);
      5'd3:    a = CORD_ZW'(85004756);
      5'd4:    a = CORD_ZW'(42667331);
      5'd5:    a = CORD_ZW'(21354465);
      5'd6:    a = CORD_ZW'(10680862);
      5'd7:    a = CORD_ZW'(5340245);
      5'd8:    a = CORD_ZW'(2670163);
      5'd9:    a = CORD_ZW'(1335087);
      5'd10:   a = CORD_ZW'(667544);
      5'd11:   a = CORD_ZW'(333772);
      5'd12:   a = CORD_ZW'(166886);
      5'd13:   a = CORD_ZW'(83443);
      5'd14:   a = CORD_ZW'(41722);
      5'd15:   a = CORD_ZW'(20861);
      5'd16:   a = CORD_ZW'(10430);
      5'd17:   a = CORD_ZW'(5215);
      5'd18:   a = CORD_ZW'(2608);
      5'd19:   a = CORD_ZW'(1304);
      5'd20:   a = CORD_ZW'(652);
      5'd21:   a = CORD_ZW'(326);
      5'd22:   a = CORD_ZW'(163);
      5'd23:   a = CORD_ZW'(81);
      5'd24:   a = CORD_ZW'(41);
      5'd25:   a = CORD_ZW'(20);
      5'd26:   a = CORD_ZW'(10);
      5'd27:   a = CORD_ZW'(5);
      5'd28:   a = CORD_ZW'(3);
      5'd29:   a = CORD_ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp a wide signed sum to a signed POS_W word
  function automatic logic signed [POS_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic all_one;
    logic any_one;
    logic signed [POS_W-1:0] r;
    all_one = &v[SAT_W-1:POS_W-1];
    any_one = |v[SAT_W-1:POS_W-1];
    if (all_one || !any_one) begin
      r = v[POS_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/vks_in_if.sv =====
// Input channel: control and tick items.
`timescale 1ns / 1ps
interface vks_in_if;
  import vks_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [ACC_W-1:0] accel;
  logic signed [YAW_W-1:0] yaw_rate;

  modport source(output valid, kind, accel, yaw_rate, input ready);
  modport sink(input valid, kind, accel, yaw_rate, output ready);
endinterface

// ===== hdl/vks_out_if.sv =====
// Result channel: pose and speed after each tick.
`timescale 1ns / 1ps
interface vks_out_if;
  import vks_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANGLE_BITS-1:0]   heading_out;
  logic signed [VEL_W-1:0] speed;

  modport source(output valid, pos_x, pos_y, heading_out, speed, input ready);
  modport sink(input valid, pos_x, pos_y, heading_out, speed, output ready);
endinterface

// ===== hdl/vks_dp.sv =====
// Datapath: state registers, shared multiplier, CORDIC and output register.
`timescale 1ns / 1ps
module vks_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vks_pkg::DT_W-1:0]        cfg_wdata,
  input  logic signed [vks_pkg::ACC_W-1:0] in_accel,
  input  logic signed [vks_pkg::YAW_W-1:0] in_yaw_rate,
  input  vks_pkg::vks_cmd_t               cmd,
  output vks_pkg::vks_sts_t               sts,
  vks_out_if.source                       out_ch
);
  import vks_pkg::*;

  localparam int RS_W = MUL_P_W + 1;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Configuration and kinematic state
  logic [DT_W-1:0]         tick_period_r;
  logic signed [ACC_W-1:0] accel_r;
  logic signed [YAW_W-1:0] yaw_r;
  logic signed [VEL_W-1:0] vel_r;
  logic [ANGLE_BITS-1:0]   head_r;
  logic signed [POS_W-1:0] px_r;
  logic signed [POS_W-1:0] py_r;

  // Working registers
  logic signed [MUL_P_W-1:0]   prod_r;
  logic signed [POS_W-1:0]     step_r;
  logic signed [CORD_W-1:0]    cx_r;
  logic signed [CORD_W-1:0]    cy_r;
  logic signed [CORD_ZW-1:0]   cz_r;
  logic [1:0]                  quad_r;
  logic signed [TRIG_BITS-1:0] cos_r;
  logic signed [TRIG_BITS-1:0] sin_r;

  // Output register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_px_r;
  logic signed [POS_W-1:0] out_py_r;
  logic [ANGLE_BITS-1:0]   out_head_r;
  logic signed [VEL_W-1:0] out_vel_r;

  // Multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] dt_b;

  assign dt_b = MUL_B_W'(signed'({1'b0, tick_period_r}));

  always_comb begin
    case (cmd.mul_sel)
      MUL_DV: begin
        mul_a = MUL_A_W'(accel_r);
        mul_b = dt_b;
      end
      MUL_DH: begin
        mul_a = MUL_A_W'(yaw_r);
        mul_b = dt_b;
      end
      MUL_STEP: begin
        mul_a = MUL_A_W'(vel_r);
        mul_b = dt_b;
      end
      MUL_DX: begin
        mul_a = MUL_A_W'(step_r);
        mul_b = MUL_B_W'(cos_r);
      end
      MUL_DY: begin
        mul_a = MUL_A_W'(step_r);
        mul_b = MUL_B_W'(sin_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round-to-nearest shifts of the product
  logic signed [RS_W-1:0] prod_ext;
  logic signed [RS_W-1:0] rnd_dt;
  logic signed [RS_W-1:0] rnd_trig;

  assign prod_ext = RS_W'(prod_r);
  assign rnd_dt   = (prod_ext + RS_W'(1 << (DT_W - 1))) >>> DT_W;
  assign rnd_trig = (prod_ext + RS_W'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;

  // Saturating sums
  logic signed [SAT_W-1:0] vel_sum;
  logic signed [SAT_W-1:0] px_sum;
  logic signed [SAT_W-1:0] py_sum;

  assign vel_sum = SAT_W'(vel_r) + SAT_W'(rnd_dt);
  assign px_sum  = SAT_W'(px_r) + SAT_W'(rnd_trig);
  assign py_sum  = SAT_W'(py_r) + SAT_W'(rnd_trig);

  // CORDIC rotation step
  logic [31:0]               ang32;
  logic signed [CORD_W-1:0]  cx_sh;
  logic signed [CORD_W-1:0]  cy_sh;
  logic signed [CORD_ZW-1:0] atan_i;

  assign ang32  = 32'(head_r) << (32 - ANGLE_BITS);
  assign cx_sh  = cx_r >>> cmd.cord_idx;
  assign cy_sh  = cy_r >>> cmd.cord_idx;
  assign atan_i = cord_atan(cmd.cord_idx);

  // Rounded CORDIC outputs and quadrant fold
  logic signed [CORD_W-1:0]    cx_rnd;
  logic signed [CORD_W-1:0]    cy_rnd;
  logic signed [TRIG_BITS-1:0] c_q;
  logic signed [TRIG_BITS-1:0] s_q;
  logic signed [TRIG_BITS-1:0] cos_nxt;
  logic signed [TRIG_BITS-1:0] sin_nxt;

  assign cx_rnd = (cx_r + CORD_W'(1 << (CORD_RSH - 1))) >>> CORD_RSH;
  assign cy_rnd = (cy_r + CORD_W'(1 << (CORD_RSH - 1))) >>> CORD_RSH;
  assign c_q    = cx_rnd[TRIG_BITS-1:0];
  assign s_q    = cy_rnd[TRIG_BITS-1:0];

  always_comb begin
    case (quad_r)
      QUAD_0: begin
        cos_nxt = c_q;
        sin_nxt = s_q;
      end
      QUAD_1: begin
        cos_nxt = -s_q;
        sin_nxt = c_q;
      end
      QUAD_2: begin
        cos_nxt = -c_q;
        sin_nxt = -s_q;
      end
      QUAD_3: begin
        cos_nxt = s_q;
        sin_nxt = -c_q;
      end
      default: begin
        cos_nxt = c_q;
        sin_nxt = s_q;
      end
    endcase
  end

  // Architectural state, set by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
      accel_r       <= '0;
      yaw_r         <= '0;
      vel_r         <= '0;
      head_r        <= '0;
      px_r          <= '0;
      py_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_period_r <= cfg_wdata;
      end
      if (cmd.load_ctrl) begin
        accel_r <= in_accel;
        yaw_r   <= in_yaw_rate;
      end
      if (cmd.upd_vel) begin
        vel_r <= sat_word(vel_sum);
      end
      if (cmd.upd_head) begin
        head_r <= head_r + rnd_dt[ANGLE_BITS-1:0];
      end
      if (cmd.upd_px) begin
        px_r <= sat_word(px_sum);
      end
      if (cmd.upd_py) begin
        py_r <= sat_word(py_sum);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.load_step) begin
      step_r <= rnd_dt[POS_W-1:0];
    end
    if (cmd.cord_init) begin
      quad_r <= ang32[31:30];
      cx_r   <= CORD_GAIN;
      cy_r   <= '0;
      cz_r   <= CORD_ZW'(ang32[29:0]);
    end else if (cmd.cord_step) begin
      if (!cz_r[CORD_ZW-1]) begin
        cx_r <= cx_r - cy_sh;
        cy_r <= cy_r + cx_sh;
        cz_r <= cz_r - atan_i;
      end else begin
        cx_r <= cx_r + cy_sh;
        cy_r <= cy_r - cx_sh;
        cz_r <= cz_r + atan_i;
      end
    end
    if (cmd.trig_load) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
    if (cmd.out_load) begin
      out_px_r   <= px_r;
      out_py_r   <= py_r;
      out_head_r <= head_r;
      out_vel_r  <= vel_r;
    end
  end

  assign sts.out_busy       = out_valid_r && !out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x       = out_px_r;
  assign out_ch.pos_y       = out_py_r;
  assign out_ch.heading_out = out_head_r;
  assign out_ch.speed       = out_vel_r;

endmodule

// ===== hdl/vks_ctrl.sv =====
// Controller: sequences one tick through multiplier and CORDIC steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  vks_pkg::vks_sts_t sts,
  output vks_pkg::vks_cmd_t cmd
);
  import vks_pkg::*;

  vks_state_t state_r;
  vks_state_t state_nxt;
  cord_idx_t  iter_r;
  cord_idx_t  iter_nxt;

  // State and iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    iter_nxt     = iter_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MUL_NONE;
    cmd.cord_idx = iter_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind) begin
            state_nxt = ST_DV;
          end else begin
            cmd.load_ctrl = 1'b1;
          end
        end
      end
      ST_DV: begin
        cmd.mul_sel = MUL_DV;
        state_nxt   = ST_DH;
      end
      ST_DH: begin
        cmd.mul_sel = MUL_DH;
        cmd.upd_vel = 1'b1;
        state_nxt   = ST_HEAD;
      end
      ST_HEAD: begin
        // velocity is already updated here
        cmd.mul_sel  = MUL_STEP;
        cmd.upd_head = 1'b1;
        state_nxt    = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.load_step = 1'b1;
        cmd.cord_init = 1'b1;
        iter_nxt      = '0;
        state_nxt     = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == CORD_IW'(CORD_STEPS - 1)) begin
          state_nxt = ST_CFIN;
        end
      end
      ST_CFIN: begin
        cmd.trig_load = 1'b1;
        state_nxt     = ST_MX;
      end
      ST_MX: begin
        cmd.mul_sel = MUL_DX;
        state_nxt   = ST_MY;
      end
      ST_MY: begin
        cmd.mul_sel = MUL_DY;
        cmd.upd_px  = 1'b1;
        state_nxt   = ST_PY;
      end
      ST_PY: begin
        cmd.upd_py = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // wait for a free output register
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `VKS_ASSERT_NXT(a_tick_starts, clk, rst_n, in_valid && in_ready && in_kind, state_r == ST_DV, "tick item did not start a step")
  `VKS_ASSERT_NXT(a_ctrl_stays, clk, rst_n, in_valid && in_ready && !in_kind, state_r == ST_IDLE, "control item left idle")
  `VKS_ASSERT_IMP(a_cord_count, clk, rst_n, state_r == ST_CORD && state_nxt != ST_CORD, iter_r == CORD_IW'(CORD_STEPS - 1), "CORDIC left early")
  `VKS_ASSERT_NXT(a_out_done, clk, rst_n, cmd.out_load, state_r == ST_IDLE && !cmd.upd_px, "result load not followed by idle")

endmodule

// ===== hdl/vehicle_kinematic_step.sv =====
// Top level: dead-reckoning step unit for a planar vehicle.
//
// Channels: in_ch carries items; kind 0 stores accel and yaw_rate and
// gives no result, kind 1 runs one Euler step of length tick_period and
// gives one result on out_ch (pos_x, pos_y, heading_out, speed).
// cfg_we/cfg_wdata write tick_period (unsigned Q0.16 seconds).
// A tick runs the 30-iteration CORDIC plus five passes through the
// single shared 32x17 multiplier before out_ch.valid rises; a control
// item is stored straight from idle. in_ready is high only while idle,
// so no new item is taken until the current tick is through.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a following tick holds in its last
// step until the register frees.
// Reset (rst_n, synchronous) clears position, heading, velocity and the
// stored commands, sets tick_period to 0.1 s and drops out_ch.valid.
`timescale 1ns / 1ps
module vehicle_kinematic_step (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [vks_pkg::DT_W-1:0] cfg_wdata,
  vks_in_if.sink                   in_ch,
  vks_out_if.source                out_ch
);
  import vks_pkg::*;

  vks_cmd_t cmd;
  vks_sts_t sts;

  vks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vks_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_accel    (in_ch.accel),
    .in_yaw_rate (in_ch.yaw_rate),
    .cmd         (cmd),
    .sts         (sts),
    .out_ch      (out_ch)
  );

endmodule
